@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds at an edge, consequent holds at the next edge
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brcm_pkg.sv @@
// ----------------------------------------------------------------------------
// brcm_pkg
// Types and constants of the block rms current meter.
// ----------------------------------------------------------------------------
package brcm_pkg;

  // word widths
  localparam int CAL_W     = 32;   // gain and offset registers
  localparam int WLEN_W    = 16;   // window length and sample count
  localparam int RMS_W     = 32;   // rms result
  localparam int WIN_W     = 16;   // window number
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 33;   // signed operand of the shared multiplier
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 64;
  localparam int DIV_W     = WLEN_W + 1;
  localparam int REM_W     = 36;   // partial remainder of divide and root
  localparam int SHIFT_R   = 8;    // q.24 down to q.16

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN   = 2'd2;

  // reset values
  localparam logic [CAL_W-1:0]  GAIN_RST   = 32'sd28421;
  localparam logic [CAL_W-1:0]  OFFSET_RST = -32'sd233109;
  localparam logic [WLEN_W-1:0] WLEN_RST   = 16'd500;

  // iteration counts of the root unit
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // operation of the front end
  typedef enum logic [2:0] {
    FE_NONE,
    FE_MUL_CAL,
    FE_CAL,
    FE_MUL_SQ,
    FE_ACC
  } fe_op_e;

  typedef struct packed {
    fe_op_e op;
    logic   clear;
  } fe_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } root_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

@@ rtl/brcm_if.sv @@
// ----------------------------------------------------------------------------
// brcm_if
// Valid/ready channels of the block rms current meter.
// ----------------------------------------------------------------------------

// sample channel
interface brcm_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

// result channel
interface brcm_out_if;
  logic                       valid;
  logic                       ready;
  logic [brcm_pkg::RMS_W-1:0] rms_q16;
  logic [brcm_pkg::WIN_W-1:0] window_number;
  modport source (output valid, output rms_q16, output window_number, input ready);
  modport sink (input valid, input rms_q16, input window_number, output ready);
endinterface

// register write channel
interface brcm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [brcm_pkg::CFG_IDX_W-1:0] index;
  logic [brcm_pkg::CAL_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/brcm_front.sv @@
// ----------------------------------------------------------------------------
// brcm_front
// Calibration and square accumulation around one shared multiplier.
// ----------------------------------------------------------------------------
module brcm_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brcm_pkg::fe_ctrl_t            ctrl_i,
  input  logic [SAMPLE_BITS-1:0]        raw_i,
  input  logic [brcm_pkg::CAL_W-1:0]    gain_i,
  input  logic [brcm_pkg::CAL_W-1:0]    offset_i,
  output logic [brcm_pkg::SUM_W-1:0]    sum_o
);

  localparam int MW = brcm_pkg::MUL_W;
  localparam int PW = brcm_pkg::PROD_W;
  localparam int CW = brcm_pkg::CAL_W;
  localparam int SW = brcm_pkg::SUM_W;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_full;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [PW-1:0] cal_v, cal_sh;
  logic [CW-1:0]        cur, mag;
  logic [CW-1:0]        mag_q, mag_d;
  logic [SW:0]          sum_ext;
  logic [SW-1:0]        sum_q, sum_d;

  // operand select for the shared multiplier
  always_comb begin
    if (ctrl_i.op == brcm_pkg::FE_MUL_SQ) begin
      mul_a = $signed({1'b0, mag_q});
      mul_b = $signed({1'b0, mag_q});
    end else begin
      mul_a = $signed({{(MW-SAMPLE_BITS){1'b0}}, raw_i});
      mul_b = $signed({gain_i[CW-1], gain_i});
    end
  end

  assign prod_full = mul_a * mul_b;

  // offset, floor shift to q15.16 and saturation
  assign cal_v  = prod_q + $signed({{(PW-CW){offset_i[CW-1]}}, offset_i});
  assign cal_sh = cal_v >>> brcm_pkg::SHIFT_R;

  always_comb begin
    if ((&cal_sh[PW-1:CW-1]) || !(|cal_sh[PW-1:CW-1])) begin
      cur = cal_sh[CW-1:0];
    end else if (cal_sh[PW-1]) begin
      cur = {1'b1, {(CW-1){1'b0}}};
    end else begin
      cur = {1'b0, {(CW-1){1'b1}}};
    end
    mag = cur[CW-1] ? (~cur + 1'b1) : cur;
  end

  // saturating accumulate of the square
  assign sum_ext = {1'b0, sum_q} + {1'b0, prod_q[SW-1:0]};

  always_comb begin
    prod_d = prod_q;
    mag_d  = mag_q;
    sum_d  = sum_q;
    case (ctrl_i.op)
      brcm_pkg::FE_MUL_CAL, brcm_pkg::FE_MUL_SQ: begin
        prod_d = prod_full;
      end
      brcm_pkg::FE_CAL: begin
        mag_d = mag;
      end
      brcm_pkg::FE_ACC: begin
        sum_d = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
      end
      default: begin
      end
    endcase
    if (ctrl_i.clear) begin
      sum_d = '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mag_q  <= mag_d;
  end

  // running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/brcm_root.sv @@
// ----------------------------------------------------------------------------
// brcm_root
// Restoring divide then bit-pair square root on one shared subtractor.
// ----------------------------------------------------------------------------
module brcm_root (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brcm_pkg::root_ctrl_t       ctrl_i,
  output brcm_pkg::root_stat_t       stat_o,
  output logic [brcm_pkg::RMS_W-1:0] root_o
);

  localparam int SW = brcm_pkg::SUM_W;
  localparam int RW = brcm_pkg::REM_W;
  localparam int DW = brcm_pkg::DIV_W;
  localparam int OW = brcm_pkg::RMS_W;
  localparam int NW = brcm_pkg::STEP_W;
  localparam logic [NW-1:0] DIV_LAST  = NW'(brcm_pkg::DIV_STEPS - 1);
  localparam logic [NW-1:0] SQRT_LAST = NW'(brcm_pkg::SQRT_STEPS - 1);

  logic [SW-1:0] x_q, x_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [OW-1:0] root_q, root_d;
  logic [DW-1:0] div_q, div_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          sqrt_q, sqrt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW-1:0] op_a, op_b;
  logic [RW:0]   diff;
  logic          fits;

  // shared subtractor, operands by phase
  always_comb begin
    if (sqrt_q) begin
      op_a = {rem_q[RW-3:0], x_q[SW-1 -: 2]};
      op_b = {{(RW-OW-2){1'b0}}, root_q, 2'b01};
    end else begin
      op_a = {rem_q[RW-2:0], x_q[SW-1]};
      op_b = {{(RW-DW){1'b0}}, div_q};
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign fits = !diff[RW];

  // step sequencing
  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    sqrt_d = sqrt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (ctrl_i.start) begin
      x_d    = ctrl_i.dividend;
      rem_d  = '0;
      root_d = '0;
      div_d  = ctrl_i.divisor;
      cnt_d  = '0;
      sqrt_d = 1'b0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = fits ? diff[RW-1:0] : op_a;
      cnt_d = cnt_q + 1'b1;
      if (!sqrt_q) begin
        // quotient bits enter from the bottom of x
        x_d = {x_q[SW-2:0], fits};
        if (cnt_q == DIV_LAST) begin
          rem_d  = '0;
          cnt_d  = '0;
          sqrt_d = 1'b1;
        end
      end else begin
        x_d    = {x_q[SW-3:0], 2'b00};
        root_d = {root_q[OW-2:0], fits};
        if (cnt_q == SQRT_LAST) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

@@ rtl/block_rms_current_meter_top.sv @@
// ----------------------------------------------------------------------------
// block_rms_current_meter_top
// Windowed rms of a linearly calibrated current sample stream.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one raw converter sample per word; only low SAMPLE_BITS bits used.
//   out_o : one word per closed window: rms in q16.16 amperes and a window
//           number that wraps at 65536.
//   cfg_i : register writes (gain, offset, window length), always ready;
//           write only while the block is idle.
// Sequence
//   A sample that does not close a window passes twice through the shared
//   multiplier (gain, then square) with the calibration step between, then
//   the accumulate and the window check, before in_i.ready rises again.
//   A sample that closes a window then loads the root unit, which runs 64
//   restoring divide steps and 32 square-root steps on one subtractor; the
//   result then loads the output register once that register is free.
// Reset
//   Sum, sample count and window number clear; the registers take their
//   defaults; no result is pending.
// Back-pressure
//   A result waits in the output register while later samples are taken; a
//   second window close waits in the root unit until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_rms_current_meter_top #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  brcm_in_if.sink        in_i,
  brcm_out_if.source     out_o,
  brcm_cfg_if.sink       cfg_i
);

  localparam int CW = brcm_pkg::CAL_W;
  localparam int LW = brcm_pkg::WLEN_W;
  localparam int OW = brcm_pkg::RMS_W;
  localparam int WW = brcm_pkg::WIN_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MCAL = 3'd1;
  localparam logic [2:0] ST_CAL  = 3'd2;
  localparam logic [2:0] ST_MSQ  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_CHK  = 3'd5;
  localparam logic [2:0] ST_ROOT = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [SAMPLE_BITS-1:0] raw_q, raw_d;
  logic [CW-1:0]          gain_q, gain_d;
  logic [CW-1:0]          offset_q, offset_d;
  logic [LW-1:0]          wlen_q, wlen_d;
  logic [LW-1:0]          count_q, count_d;
  logic [WW-1:0]          window_q, window_d;
  logic [OW-1:0]          rms_q, rms_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_take, close, load;
  brcm_pkg::fe_ctrl_t     fe_ctrl;
  brcm_pkg::root_ctrl_t   root_ctrl;
  brcm_pkg::root_stat_t   root_stat;
  logic [brcm_pkg::SUM_W-1:0] sum;
  logic [OW-1:0]          root_val;

  brcm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fe_ctrl),
    .raw_i    (raw_q),
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .sum_o    (sum)
  );

  brcm_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (root_ctrl),
    .stat_o (root_stat),
    .root_o (root_val)
  );

  // handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign close       = (state_q == ST_CHK) && (count_q == wlen_q);
  assign load        = (state_q == ST_ROOT) && root_stat.done &&
                       (!out_valid_q || out_o.ready);

  // front end operation per state
  always_comb begin
    case (state_q)
      ST_MCAL: fe_ctrl.op = brcm_pkg::FE_MUL_CAL;
      ST_CAL:  fe_ctrl.op = brcm_pkg::FE_CAL;
      ST_MSQ:  fe_ctrl.op = brcm_pkg::FE_MUL_SQ;
      ST_ACC:  fe_ctrl.op = brcm_pkg::FE_ACC;
      default: fe_ctrl.op = brcm_pkg::FE_NONE;
    endcase
    fe_ctrl.clear = close;
  end

  // divisor of zero count means a full 65536 sample window
  assign root_ctrl.start    = close;
  assign root_ctrl.dividend = sum;
  assign root_ctrl.divisor  = {(count_q == '0), count_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    raw_d   = raw_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          raw_d   = in_i.raw_sample;
          state_d = ST_MCAL;
        end
      end
      ST_MCAL: state_d = ST_CAL;
      ST_CAL:  state_d = ST_MSQ;
      ST_MSQ:  state_d = ST_ACC;
      ST_ACC: begin
        count_d = count_q + 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (close) begin
          count_d = '0;
          state_d = ST_ROOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROOT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    rms_d       = rms_q;
    window_d    = window_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      rms_d       = root_val;
      window_d    = window_q + 1'b1;
      out_valid_d = 1'b1;
    end
  end

  // register writes, unknown index ignored
  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    wlen_d   = wlen_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        brcm_pkg::CFG_GAIN:   gain_d   = cfg_i.data;
        brcm_pkg::CFG_OFFSET: offset_d = cfg_i.data;
        brcm_pkg::CFG_WLEN:   wlen_d   = cfg_i.data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    rms_q <= rms_d;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      window_q    <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= brcm_pkg::GAIN_RST;
      offset_q    <= brcm_pkg::OFFSET_RST;
      wlen_q      <= brcm_pkg::WLEN_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
      gain_q      <= gain_d;
      offset_q    <= offset_d;
      wlen_q      <= wlen_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.rms_q16       = rms_q;
  assign out_o.window_number = window_q;

  // checks
  `ASSERT_IMP(a_ready_root_idle, clk_i, rst_ni, in_i.ready, !root_stat.busy, "sample taken while root unit busy")
  `ASSERT_IMP(a_result_from_root, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_ROOT, "result not from root state")
  `ASSERT_IMP(a_window_step, clk_i, rst_ni, $rose(out_valid_q), window_q == $past(window_q) + 1'b1, "window number skipped")
  `ASSERT_NXT(a_close_clears, clk_i, rst_ni, close, (sum == '0) && (count_q == '0), "window close did not clear")

endmodule
